[hw/rtl/clst_pkg.sv]
`default_nettype none
package clst_pkg;

    localparam int MAX_DIMS     = 8;
    localparam int MAX_CLUSTERS = 16;
    localparam int TREE_N       = 8;

    localparam int CL_W    = $clog2(MAX_CLUSTERS);
    localparam int NCL_W   = CL_W + 1;
    localparam int DIMS_W  = $clog2(MAX_DIMS) + 1;
    localparam int X_W     = 16;
    localparam int SUM_W   = 26;
    localparam int CNT_W   = 11;
    localparam int M_W     = 28;
    localparam int SQ_W    = 2 * M_W;
    localparam int ACC_W   = SQ_W + $clog2(TREE_N);
    localparam int DIVR_W  = 2 * CNT_W;
    localparam int DELTA_W = 38;
    localparam int DIFF_W  = ACC_W + 2;
    localparam int ROW_W   = MAX_DIMS * SUM_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_DIMS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0]  COUNT_MAX      = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  SMALL_LIMIT    = CNT_W'(2);
    localparam logic [DIMS_W-1:0] DIMS_RESET     = DIMS_W'(MAX_DIMS);
    localparam logic [NCL_W-1:0]  CLUSTERS_RESET = NCL_W'(2);

    localparam logic signed [DIFF_W-1:0] DELTA_MAX = DIFF_W'((64'sd1 <<< (DELTA_W - 1)) - 1);
    localparam logic signed [DIFF_W-1:0] DELTA_MIN = -DIFF_W'(64'sd1 <<< (DELTA_W - 1));

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_EV_RD,
        S_EV_LANE,
        S_EV_WAIT,
        S_EV_DIV,
        S_EV_NEXT,
        S_EV_DEC,
        S_MV_RD_SRC,
        S_MV_WR_SRC,
        S_MV_RD_DST,
        S_MV_WR_DST,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    function automatic logic [DIMS_W-1:0] clamp_dims(input logic [DIMS_W-1:0] raw);
        logic [DIMS_W-1:0] r;
        r = raw;
        if (raw < DIMS_W'(1))
            r = DIMS_W'(1);
        else if (raw > DIMS_W'(MAX_DIMS))
            r = DIMS_W'(MAX_DIMS);
        return r;
    endfunction

    function automatic logic [NCL_W-1:0] clamp_clusters(input logic [NCL_W-1:0] raw);
        logic [NCL_W-1:0] r;
        r = raw;
        if (raw < NCL_W'(2))
            r = NCL_W'(2);
        else if (raw > NCL_W'(MAX_CLUSTERS))
            r = NCL_W'(MAX_CLUSTERS);
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/clst_if.sv]
`default_nettype none
interface clst_req_if import clst_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [CL_W-1:0]       cluster;
    logic signed [X_W-1:0] x0;
    logic signed [X_W-1:0] x1;
    logic signed [X_W-1:0] x2;
    logic signed [X_W-1:0] x3;
    logic signed [X_W-1:0] x4;
    logic signed [X_W-1:0] x5;
    logic signed [X_W-1:0] x6;
    logic signed [X_W-1:0] x7;
    modport source (output valid, req_type, cluster, x0, x1, x2, x3, x4, x5, x6, x7,
                    input ready);
    modport sink (input valid, req_type, cluster, x0, x1, x2, x3, x4, x5, x6, x7,
                  output ready);
endinterface

interface clst_rsp_if import clst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CL_W-1:0]           dest_cluster;
    logic                      moved;
    logic signed [DELTA_W-1:0] delta;
    modport source (output valid, dest_cluster, moved, delta, input ready);
    modport sink (input valid, dest_cluster, moved, delta, output ready);
endinterface

interface clst_cfg_if import clst_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/clst_ram.sv]
`default_nettype none
module clst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/clst_lane.sv]
`default_nettype none
module clst_lane import clst_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    go,
    input  wire logic                    en,
    input  wire logic [CNT_W-1:0]        n,
    input  wire logic signed [SUM_W-1:0] s,
    input  wire logic signed [X_W-1:0]   x,
    output logic                         sq_valid,
    output logic [SQ_W-1:0]              sq
);
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  en_reg;
    logic signed [M_W-1:0] m_reg;
    logic signed [M_W-1:0] m_next;
    logic signed [SQ_W-1:0] sq_full;
    logic [SQ_W-1:0]       sq_reg;

    // m = n*x - s, fits in M_W bits for every count and coordinate
    assign m_next = M_W'($signed({{(M_W-CNT_W){1'b0}}, n}) * M_W'(x)) - M_W'(s);
    assign sq_full = SQ_W'(m_reg) * SQ_W'(m_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg  <= m_next;
        en_reg <= en;
        sq_reg <= en_reg ? sq_full : '0;
    end

    assign sq_valid = v2_reg;
    assign sq       = sq_reg;
endmodule
`default_nettype wire

[hw/rtl/clst_merge.sv]
`default_nettype none
module clst_merge import clst_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [SQ_W-1:0]  sq [MAX_DIMS],
    output logic                  sum_valid,
    output logic [ACC_W-1:0]      sum
);
    logic [SQ_W-1:0]   pad [TREE_N];
    logic [SQ_W:0]     l1_reg [TREE_N/2];
    logic [SQ_W+1:0]   l2_reg [TREE_N/4];
    logic [ACC_W-1:0]  l3_reg;
    logic [2:0]        v_reg;

    always_comb
    begin
        for (int i = 0; i < TREE_N; i++)
        begin
            pad[i] = '0;
            if (i < MAX_DIMS)
                pad[i] = sq[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TREE_N/2; i++)
            l1_reg[i] <= {1'b0, pad[2*i]} + {1'b0, pad[2*i+1]};
        for (int i = 0; i < TREE_N/4; i++)
            l2_reg[i] <= {1'b0, l1_reg[2*i]} + {1'b0, l1_reg[2*i+1]};
        l3_reg <= ACC_W'({1'b0, l2_reg[0]}) + ACC_W'({1'b0, l2_reg[1]});
    end

    assign sum_valid = v_reg[2];
    assign sum       = l3_reg;
endmodule
`default_nettype wire

[hw/rtl/clst_div.sv]
`default_nettype none
module clst_div import clst_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_req_t    rq,
    output logic             done,
    output logic [ACC_W-1:0] quot
);
    localparam int CW = $clog2(ACC_W + 1);

    logic              run_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [ACC_W-1:0]  quo_reg;
    logic [DIVR_W-1:0] dvs_reg;
    logic [DIVR_W:0]   rem_sh;
    logic [DIVR_W:0]   rem_sub;
    logic              fits;

    // restoring division, one quotient bit per cycle
    assign rem_sh  = {rem_reg, quo_reg[ACC_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign fits    = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (rq.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(ACC_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq.start)
        begin
            rem_reg <= '0;
            quo_reg <= rq.dividend;
            dvs_reg <= rq.divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
            quo_reg <= {quo_reg[ACC_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule
`default_nettype wire

[hw/rtl/cluster_transfer_local_search_core.sv]
// channel | dir | transaction
// cfg     | in  | register write: index 0 dims_in_use, index 1 clusters_in_use
// req     | in  | one item: req_type, cluster, x0..x7
// rsp     | out | one result: dest_cluster, moved, delta
//
// an add reads and rewrites the sum row unless the count is full; a transfer
// not evaluated goes straight to rsp; a transfer runs each nonempty cluster in use
// through the lane and merge pipeline and the bit-serial divider (59 steps);
// empty candidates skip them; a move rewrites the source and destination sum rows
// reset clears counts and row valid bits at once, no clearing pass
// one item at a time; the result register lets the next item start while rsp stalls
`default_nettype none
module cluster_transfer_local_search_core import clst_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    clst_cfg_if.sink   cfg,
    clst_req_if.sink   req,
    clst_rsp_if.source rsp
);
    state_t state_reg;
    state_t state_next;

    logic [DIMS_W-1:0] dims_reg;
    logic [NCL_W-1:0]  ncl_reg;
    logic [DIMS_W-1:0] dims_act;
    logic [NCL_W-1:0]  ncl_act;

    logic [CNT_W-1:0] cnt_reg [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0] rowv_reg;
    logic             rd_ok_reg;

    logic                  req_type_reg;
    logic [CL_W-1:0]       ci_reg;
    logic signed [X_W-1:0] x_reg [MAX_DIMS];
    logic signed [X_W-1:0] x_in [MAX_DIMS];
    logic [CL_W-1:0]       cur_reg;
    logic                  aph_reg;
    logic                  have_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [DIVR_W-1:0]     dvs_reg;
    logic [ACC_W-1:0]      val_reg;
    logic [ACC_W-1:0]      a_reg;
    logic [ACC_W-1:0]      best_reg;
    logic [CL_W-1:0]       bestj_reg;

    logic [CL_W-1:0]           res_dest_reg;
    logic                      res_moved_reg;
    logic signed [DELTA_W-1:0] res_delta_reg;
    logic                      rsp_valid_reg;
    logic [CL_W-1:0]           rsp_dest_reg;
    logic                      rsp_moved_reg;
    logic signed [DELTA_W-1:0] rsp_delta_reg;

    logic [CL_W-1:0]  raddr;
    logic [CL_W-1:0]  waddr;
    logic             ram_we;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] row_q;
    logic [ROW_W-1:0] wdata;
    logic             sub_row;
    logic [CL_W-1:0]  cidx;
    logic [CNT_W-1:0] cnt_sel;
    logic             lane_go;
    logic             req_ready;
    logic             out_load;

    logic [SQ_W-1:0]  sq [MAX_DIMS];
    logic [MAX_DIMS-1:0] sq_vld;
    logic             mrg_valid;
    logic [ACC_W-1:0] mrg_sum;
    div_req_t         drq;
    logic             div_done;
    logic [ACC_W-1:0] div_q;

    logic [NCL_W-1:0]  j_first;
    logic [NCL_W-1:0]  j_next;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] diff_sat;
    logic [CNT_W-1:0]  n_dec;
    logic [CNT_W:0]    n_inc;

    assign dims_act = clamp_dims(dims_reg);
    assign ncl_act  = clamp_clusters(ncl_reg);
    assign cfg.ready = 1'b1;

    assign x_in[0] = req.x0;
    assign x_in[1] = req.x1;
    assign x_in[2] = req.x2;
    assign x_in[3] = req.x3;
    assign x_in[4] = req.x4;
    assign x_in[5] = req.x5;
    assign x_in[6] = req.x6;
    assign x_in[7] = req.x7;

    assign cnt_sel = cnt_reg[cidx];
    assign row_q   = rd_ok_reg ? ram_rdata : '0;

    assign j_first = (ci_reg == CL_W'(0)) ? NCL_W'(1) : NCL_W'(0);
    assign j_next  = ({1'b0, cur_reg} + NCL_W'(1) == {1'b0, ci_reg}) ?
                     {1'b0, cur_reg} + NCL_W'(2) : {1'b0, cur_reg} + NCL_W'(1);

    assign diff = $signed({2'b00, best_reg}) - $signed({2'b00, a_reg});
    assign diff_sat = (diff > DELTA_MAX) ? DELTA_MAX : ((diff < DELTA_MIN) ? DELTA_MIN : diff);

    assign n_dec = n_reg - CNT_W'(1);
    assign n_inc = {1'b0, n_reg} + (CNT_W+1)'(1);

    // sum row update, every coordinate of the store, wrapping
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (sub_row)
                wdata[d*SUM_W +: SUM_W] = row_q[d*SUM_W +: SUM_W] - SUM_W'(x_reg[d]);
            else
                wdata[d*SUM_W +: SUM_W] = row_q[d*SUM_W +: SUM_W] + SUM_W'(x_reg[d]);
        end
    end

    clst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_sums (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_lane
        clst_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .go       (lane_go),
            .en       (DIMS_W'(d) < dims_act),
            .n        (n_reg),
            .s        ($signed(row_q[d*SUM_W +: SUM_W])),
            .x        (x_reg[d]),
            .sq_valid (sq_vld[d]),
            .sq       (sq[d])
        );
    end

    clst_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (&sq_vld),
        .sq        (sq),
        .sum_valid (mrg_valid),
        .sum       (mrg_sum)
    );

    assign drq.start    = (state_reg == S_EV_WAIT) && mrg_valid;
    assign drq.dividend = mrg_sum;
    assign drq.divisor  = dvs_reg;

    clst_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .rq   (drq),
        .done (div_done),
        .quot (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (!req.req_type)
                        state_next = (cnt_sel < COUNT_MAX) ? S_ADD_RD : S_DONE;
                    else if ({1'b0, req.cluster} < ncl_act && cnt_sel > SMALL_LIMIT)
                        state_next = S_EV_RD;
                    else
                        state_next = S_DONE;
                end
            end
            S_ADD_RD:    state_next = S_ADD_WR;
            S_ADD_WR:    state_next = S_DONE;
            S_EV_RD:     state_next = (!aph_reg && cnt_sel == '0) ? S_EV_NEXT : S_EV_LANE;
            S_EV_LANE:   state_next = S_EV_WAIT;
            S_EV_WAIT:   state_next = mrg_valid ? S_EV_DIV : S_EV_WAIT;
            S_EV_DIV:    state_next = div_done ? S_EV_NEXT : S_EV_DIV;
            S_EV_NEXT:
            begin
                if (aph_reg || j_next < ncl_act)
                    state_next = S_EV_RD;
                else
                    state_next = S_EV_DEC;
            end
            S_EV_DEC:    state_next = diff[DIFF_W-1] ? S_MV_RD_SRC : S_DONE;
            S_MV_RD_SRC: state_next = S_MV_WR_SRC;
            S_MV_WR_SRC: state_next = S_MV_RD_DST;
            S_MV_RD_DST: state_next = S_MV_WR_DST;
            S_MV_WR_DST: state_next = S_DONE;
            S_DONE:      state_next = (!rsp_valid_reg || rsp.ready) ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = 1'b0;
        raddr     = ci_reg;
        waddr     = ci_reg;
        cidx      = ci_reg;
        ram_we    = 1'b0;
        sub_row   = 1'b0;
        lane_go   = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cidx      = req.cluster;
            end
            S_ADD_WR:
                ram_we = 1'b1;
            S_EV_RD:
            begin
                raddr = cur_reg;
                cidx  = cur_reg;
            end
            S_EV_LANE:
                lane_go = 1'b1;
            S_MV_WR_SRC:
            begin
                ram_we  = 1'b1;
                sub_row = 1'b1;
            end
            S_MV_RD_DST:
            begin
                raddr = bestj_reg;
                cidx  = bestj_reg;
            end
            S_MV_WR_DST:
            begin
                ram_we = 1'b1;
                waddr  = bestj_reg;
                cidx   = bestj_reg;
            end
            S_DONE:
                out_load = !rsp_valid_reg || rsp.ready;
            default:
            begin
            end
        endcase
    end

    assign req.ready = req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dims_reg      <= DIMS_RESET;
            ncl_reg       <= CLUSTERS_RESET;
            rowv_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            for (int c = 0; c < MAX_CLUSTERS; c++)
                cnt_reg[c] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rd_ok_reg <= rowv_reg[raddr];
            if (cfg.valid)
            begin
                if (cfg.index == REG_DIMS)
                    dims_reg <= cfg.data[DIMS_W-1:0];
                else if (cfg.index == REG_CLUSTERS)
                    ncl_reg <= cfg.data[NCL_W-1:0];
            end
            if (ram_we)
                rowv_reg[waddr] <= 1'b1;
            case (state_reg)
                S_ADD_WR:    cnt_reg[cidx] <= cnt_sel + CNT_W'(1);
                S_MV_WR_SRC: cnt_reg[cidx] <= n_dec;
                S_MV_WR_DST: cnt_reg[cidx] <= n_inc[CNT_W] ? COUNT_MAX : n_inc[CNT_W-1:0];
                default:
                begin
                end
            endcase
            if (out_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                req_type_reg  <= req.req_type;
                ci_reg        <= req.cluster;
                cur_reg       <= req.cluster;
                aph_reg       <= 1'b1;
                have_reg      <= 1'b0;
                res_dest_reg  <= req.cluster;
                res_moved_reg <= 1'b0;
                res_delta_reg <= '0;
                for (int d = 0; d < MAX_DIMS; d++)
                    x_reg[d] <= x_in[d];
            end
            S_EV_RD:
            begin
                n_reg <= cnt_sel;
                if (aph_reg)
                    dvs_reg <= DIVR_W'(cnt_sel) * DIVR_W'(cnt_sel - CNT_W'(1));
                else
                    dvs_reg <= DIVR_W'(cnt_sel) * DIVR_W'({1'b0, cnt_sel} + (CNT_W+1)'(1));
                // an empty candidate costs nothing
                val_reg <= '0;
            end
            S_EV_DIV:
                if (div_done)
                    val_reg <= div_q;
            S_EV_NEXT:
            begin
                if (aph_reg)
                begin
                    a_reg   <= val_reg;
                    aph_reg <= 1'b0;
                    cur_reg <= j_first[CL_W-1:0];
                end
                else
                begin
                    if (!have_reg || val_reg < best_reg)
                    begin
                        best_reg  <= val_reg;
                        bestj_reg <= cur_reg;
                    end
                    have_reg <= 1'b1;
                    cur_reg  <= j_next[CL_W-1:0];
                end
            end
            S_EV_DEC:
            begin
                res_delta_reg <= diff_sat[DELTA_W-1:0];
                if (diff[DIFF_W-1])
                begin
                    res_dest_reg  <= bestj_reg;
                    res_moved_reg <= 1'b1;
                end
            end
            S_MV_RD_SRC:
                n_reg <= cnt_sel;
            S_MV_RD_DST:
                n_reg <= cnt_sel;
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            rsp_dest_reg  <= res_dest_reg;
            rsp_moved_reg <= res_moved_reg & req_type_reg;
            rsp_delta_reg <= res_delta_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.dest_cluster = rsp_dest_reg;
    assign rsp.moved        = rsp_moved_reg;
    assign rsp.delta        = rsp_delta_reg;
endmodule
`default_nettype wire

[hw/rtl/clst_checker.sv]
`default_nettype none
module clst_checker import clst_pkg::*; (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      req_valid,
    input wire logic                      req_ready,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic [CL_W-1:0]           rsp_dest,
    input wire logic                      rsp_moved,
    input wire logic signed [DELTA_W-1:0] rsp_delta
);
    // the block works on one transaction at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in work");

    a_move_neg: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_moved |-> rsp_delta[DELTA_W-1])
        else $error("move reported without a negative delta");

    a_stay_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_moved |-> !rsp_delta[DELTA_W-1])
        else $error("negative delta reported without a move");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest)
            && $stable(rsp_moved) && $stable(rsp_delta))
        else $error("stalled response changed");
endmodule

bind cluster_transfer_local_search_core clst_checker u_clst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_dest  (rsp.dest_cluster),
    .rsp_moved (rsp.moved),
    .rsp_delta (rsp.delta)
);
`default_nettype wire
